// ===== src/hdlc_tx_pkg.sv =====
package hdlc_tx_pkg;

    // Stuff a zero after this many consecutive ones
    localparam int unsigned ONES_BEFORE_STUFF = 5;

    // CRC-16/X.25, reflected form
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;

    localparam int unsigned RUN_W   = 3;
    localparam int unsigned LEFT_W  = 5;
    localparam int unsigned SHIFT_W = 16;

    localparam logic [RUN_W-1:0]  RUN_MAX    = '1;
    localparam logic [RUN_W-1:0]  RUN_STUFF  = RUN_W'(ONES_BEFORE_STUFF);
    localparam logic [LEFT_W-1:0] BYTE_BITS  = LEFT_W'(8);
    localparam logic [LEFT_W-1:0] CRC_BITS   = LEFT_W'(16);

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_FLAG  = 2'd1,
        CMD_BODY  = 2'd2,
        CMD_CRC   = 2'd3
    } cmd_t;

    // Serializer state: line state plus the word being shifted out
    typedef struct packed {
        logic [15:0]        crc;
        logic [RUN_W-1:0]   ones;
        logic               level;
        logic [SHIFT_W-1:0] shreg;
        logic [LEFT_W-1:0]  left;
        logic               stuff_en;
        logic               crc_en;
    } eng_state_t;

    // One emitted line bit
    typedef struct packed {
        logic line_bit;
        logic raw_bit;
        logic stuffed;
        logic last;
    } bit_out_t;

endpackage

// ===== src/hdlc_tx_bit_unit.sv =====
module hdlc_tx_bit_unit (
    input  hdlc_tx_pkg::eng_state_t st,
    output hdlc_tx_pkg::eng_state_t st_next,
    output hdlc_tx_pkg::bit_out_t   bout
);

    logic                          stuff_now;
    logic                          raw;
    logic                          fb;
    logic [hdlc_tx_pkg::RUN_W-1:0] ones_n;
    logic [15:0]                   crc_shift;

    // Stuff zero goes out whenever stuffing is enabled and the run has reached the limit
    assign stuff_now = st.stuff_en && (st.ones >= hdlc_tx_pkg::RUN_STUFF);
    assign raw       = stuff_now ? 1'b0 : st.shreg[0];

    // Ones run after this bit, saturating
    always_comb begin
        if (stuff_now || !raw) begin
            ones_n = '0;
        end else if (st.ones == hdlc_tx_pkg::RUN_MAX) begin
            ones_n = st.ones;
        end else begin
            ones_n = st.ones + hdlc_tx_pkg::RUN_W'(1);
        end
    end

    // One CRC step on the data bit
    assign fb        = st.crc[0] ^ raw;
    assign crc_shift = fb ? ((st.crc >> 1) ^ hdlc_tx_pkg::CRC_POLY) : (st.crc >> 1);

    always_comb begin
        st_next       = st;
        st_next.ones  = ones_n;
        st_next.level = raw ? st.level : ~st.level;
        if (!stuff_now) begin
            st_next.shreg = st.shreg >> 1;
            st_next.left  = st.left - hdlc_tx_pkg::LEFT_W'(1);
            if (st.crc_en) begin
                st_next.crc = crc_shift;
            end
        end
    end

    // Final bit: no data left and no trailing stuff zero due
    always_comb begin
        bout.line_bit = st_next.level;
        bout.raw_bit  = raw;
        bout.stuffed  = stuff_now;
        if (stuff_now) begin
            bout.last = (st.left == '0);
        end else begin
            bout.last = (st.left == hdlc_tx_pkg::LEFT_W'(1)) &&
                        (!st.stuff_en || (ones_n < hdlc_tx_pkg::RUN_STUFF));
        end
    end

endmodule

// ===== src/hdlc_tx_bit_stuffer_nrzi.sv =====
// HDLC transmit framer. Each input beat is one command in s_tuser (start
// frame, flag byte, body byte, append CRC) with the byte in s_tdata. Flag
// bytes go out LSB first unstuffed; body bytes feed a CRC-16/X.25 and go out
// LSB first with a zero stuffed after five ones; append CRC sends the
// inverted CRC low byte first, also stuffed. Every bit is NRZI coded and is
// one output beat, m_tlast marking the final bit of a command. Bits are
// produced by one serializer step unit at one bit per cycle while m_tready
// does not stall the output. s_tready is low while a command's bits are
// being produced.
module hdlc_tx_bit_stuffer_nrzi (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] line_bit, [1] raw_bit, [7:2] zero
    output logic       m_tuser,   // [0] stuffed
    output logic       m_tlast    // last bit of the command
);

    hdlc_tx_pkg::eng_state_t eng_reg;
    hdlc_tx_pkg::eng_state_t eng_next;
    hdlc_tx_pkg::bit_out_t   bout;
    logic                    busy_reg;
    logic                    m_tvalid_reg;
    logic [1:0]              m_bits_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;
    logic                    s_beat;
    logic                    step;
    hdlc_tx_pkg::cmd_t       cmd;

    hdlc_tx_bit_unit u_bit (
        .st      (eng_reg),
        .st_next (eng_next),
        .bout    (bout)
    );

    assign cmd      = hdlc_tx_pkg::cmd_t'(s_tuser);
    assign s_tready = !busy_reg;
    assign s_beat   = s_tvalid && s_tready;
    assign step     = busy_reg && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_bits_reg};
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Command load, serializer steps and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            eng_reg.crc      <= hdlc_tx_pkg::CRC_PRESET;
            eng_reg.ones     <= '0;
            eng_reg.level    <= 1'b0;
            eng_reg.left     <= '0;
            eng_reg.stuff_en <= 1'b0;
            eng_reg.crc_en   <= 1'b0;
        end else begin
            if (step) begin
                eng_reg      <= eng_next;
                m_tvalid_reg <= 1'b1;
                m_bits_reg   <= {bout.raw_bit, bout.line_bit};
                m_tuser_reg  <= bout.stuffed;
                m_tlast_reg  <= bout.last;
                if (bout.last) begin
                    busy_reg <= 1'b0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (s_beat) begin
                unique case (cmd)
                    hdlc_tx_pkg::CMD_START: begin
                        eng_reg.crc   <= hdlc_tx_pkg::CRC_PRESET;
                        eng_reg.ones  <= '0;
                        eng_reg.level <= 1'b0;
                    end
                    hdlc_tx_pkg::CMD_FLAG: begin
                        eng_reg.shreg    <= {8'h00, s_tdata};
                        eng_reg.left     <= hdlc_tx_pkg::BYTE_BITS;
                        eng_reg.stuff_en <= 1'b0;
                        eng_reg.crc_en   <= 1'b0;
                        busy_reg         <= 1'b1;
                    end
                    hdlc_tx_pkg::CMD_BODY: begin
                        eng_reg.shreg    <= {8'h00, s_tdata};
                        eng_reg.left     <= hdlc_tx_pkg::BYTE_BITS;
                        eng_reg.stuff_en <= 1'b1;
                        eng_reg.crc_en   <= 1'b1;
                        busy_reg         <= 1'b1;
                    end
                    hdlc_tx_pkg::CMD_CRC: begin
                        eng_reg.shreg    <= ~eng_reg.crc;
                        eng_reg.left     <= hdlc_tx_pkg::CRC_BITS;
                        eng_reg.stuff_en <= 1'b1;
                        eng_reg.crc_en   <= 1'b0;
                        busy_reg         <= 1'b1;
                    end
                    default: begin
                        busy_reg <= busy_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== tb/sv/hdlc_tx_bit_stuffer_nrzi_tb.sv =====
module hdlc_tx_bit_stuffer_nrzi_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic [1:0] s_tuser  = hdlc_tx_pkg::CMD_START; // [1:0] cmd
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] line_bit, [1] raw_bit, [7:2] zero
    logic       m_tuser;            // [0] stuffed
    logic       m_tlast;

    // Line bits still owed by the framer, oldest first
    hdlc_tx_pkg::bit_out_t line_bits_due[$];

    // Shadow of the framer's line state
    logic [15:0]                   fcs_acc;
    logic [hdlc_tx_pkg::RUN_W-1:0] ones_seen;
    logic                          line_lvl;

    int  err_cnt     = 0;
    int  cmds_sent   = 0;
    int  bits_seen   = 0;
    int  stuffs_seen = 0;
    bit  tx_steady   = 1'b0;  // sender offers back to back
    bit  rx_steady   = 1'b0;  // receiver never stalls
    int  rx_hold     = 0;     // one long receiver hold-off, in cycles

    hdlc_tx_bit_stuffer_nrzi DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Line state model ------------------------------------------------------

    function automatic void emit_line_bit(logic raw, logic stf);
        hdlc_tx_pkg::bit_out_t b;
        if (!raw) line_lvl = ~line_lvl;
        b.line_bit = line_lvl;
        b.raw_bit  = raw;
        b.stuffed  = stf;
        b.last     = 1'b0;
        line_bits_due = {line_bits_due, b};
    endfunction

    function automatic void count_ones(logic b);
        if (b) begin
            if (ones_seen != hdlc_tx_pkg::RUN_MAX) begin
                ones_seen = ones_seen + hdlc_tx_pkg::RUN_W'(1);
            end
        end else begin
            ones_seen = '0;
        end
    endfunction

    // Body and FCS bits: stuff before if a flag left a long run, and after five ones
    function automatic void emit_stuffed(logic b);
        if (ones_seen >= hdlc_tx_pkg::RUN_STUFF) begin
            emit_line_bit(1'b0, 1'b1);
            ones_seen = '0;
        end
        emit_line_bit(b, 1'b0);
        count_ones(b);
        if (ones_seen >= hdlc_tx_pkg::RUN_STUFF) begin
            emit_line_bit(1'b0, 1'b1);
            ones_seen = '0;
        end
    endfunction

    function automatic void fcs_update(logic b);
        logic fb;
        fb = fcs_acc[0] ^ b;
        fcs_acc = fcs_acc >> 1;
        if (fb) fcs_acc = fcs_acc ^ hdlc_tx_pkg::CRC_POLY;
    endfunction

    function automatic void predict_command(hdlc_tx_pkg::cmd_t c, logic [7:0] d);
        int                    first;
        int                    tail;
        logic [15:0]           fcs;
        hdlc_tx_pkg::bit_out_t b;
        first = line_bits_due.size();
        case (c)
            hdlc_tx_pkg::CMD_START: begin
                fcs_acc   = hdlc_tx_pkg::CRC_PRESET;
                ones_seen = '0;
                line_lvl  = 1'b0;
            end
            hdlc_tx_pkg::CMD_FLAG: begin
                for (int i = 0; i < 8; i++) begin
                    emit_line_bit(d[i], 1'b0);
                    count_ones(d[i]);
                end
            end
            hdlc_tx_pkg::CMD_BODY: begin
                for (int i = 0; i < 8; i++) begin
                    fcs_update(d[i]);
                    emit_stuffed(d[i]);
                end
            end
            default: begin
                fcs = ~fcs_acc;
                for (int i = 0; i < 16; i++) emit_stuffed(fcs[i]);
            end
        endcase
        // mark the final bit of this command
        if (line_bits_due.size() > first) begin
            tail = line_bits_due.size() - 1;
            b = line_bits_due[tail];
            b.last = 1'b1;
            line_bits_due[tail] = b;
        end
    endfunction

    // Sender ----------------------------------------------------------------

    // One command beat; returns on the accepting edge with valid still high
    task automatic send_cmd(hdlc_tx_pkg::cmd_t c, logic [7:0] d);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        predict_command(c, d);
        cmds_sent++;
    endtask

    // Stop offering and let every owed bit come out, plus the tail latency
    task automatic drain();
        s_tvalid <= 1'b0;
        while (line_bits_due.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    // Receiver: random per-beat stall, or one long hold-off on request
    initial begin : rx_side
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Checker ---------------------------------------------------------------

    function automatic void check_bit(string name, logic exp_v, logic got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_v, got_v);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        hdlc_tx_pkg::bit_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (line_bits_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none, %s%0b raw=%0b stuff=%0b last=%0b",
                         $time, "actual line=", m_tdata[0], m_tdata[1], m_tuser, m_tlast);
                err_cnt++;
            end else begin
                want = line_bits_due.pop_front();
                check_bit("line_bit", want.line_bit, m_tdata[0]);
                check_bit("raw_bit",  want.raw_bit,  m_tdata[1]);
                check_bit("stuffed",  want.stuffed,  m_tuser);
                check_bit("last",     want.last,     m_tlast);
                bits_seen++;
                if (m_tuser) stuffs_seen++;
            end
        end
    end

    // Tests -----------------------------------------------------------------

    function automatic logic [7:0] pick_body_byte();
        logic [7:0] ones_heavy [6] = '{8'hFF, 8'hFE, 8'h7F, 8'h1F, 8'hF8, 8'hE0};
        if ($urandom_range(0, 3) == 0) return ones_heavy[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    // Edge bytes, every command, stuffing across flags, commands with no start
    task automatic test_directed();
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'h61);     // no start yet: runs on reset state
        send_cmd(hdlc_tx_pkg::CMD_CRC,  8'h00);
        send_cmd(hdlc_tx_pkg::CMD_START, 8'hFF);
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'h7E);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'h00);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'hFF);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'h1F);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'hE0);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'h60);
        send_cmd(hdlc_tx_pkg::CMD_CRC,  8'hA5);
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'h7E);
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'hFF);     // run saturates, never stuffed
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'hFF);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'h01);     // long run from flags: stuff goes first
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'hFF);
        send_cmd(hdlc_tx_pkg::CMD_CRC,  8'h00);     // FCS right after a run of flag ones
        send_cmd(hdlc_tx_pkg::CMD_START, 8'h00);
        send_cmd(hdlc_tx_pkg::CMD_CRC,  8'hFF);     // empty frame
        send_cmd(hdlc_tx_pkg::CMD_START, 8'h5A);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'hAA);
        send_cmd(hdlc_tx_pkg::CMD_BODY, 8'h55);
        send_cmd(hdlc_tx_pkg::CMD_CRC,  8'h00);
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'h7E);
        drain();
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_backpressure();
        rx_hold   = 150;
        tx_steady = 1'b1;
        send_cmd(hdlc_tx_pkg::CMD_START, 8'h00);
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'h7E);
        for (int i = 0; i < 6; i++) send_cmd(hdlc_tx_pkg::CMD_BODY, pick_body_byte());
        send_cmd(hdlc_tx_pkg::CMD_CRC, 8'h00);
        send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'h7E);
        tx_steady = 1'b0;
        drain();
    endtask

    // Mostly well-formed frames with random bodies, some noise and cut frames
    task automatic test_random_frames();
        int         nbody;
        int         frame_no;
        logic [7:0] open_flag;
        frame_no = 0;
        while (cmds_sent < 240) begin
            // every fifth frame runs with no idling on either side
            tx_steady = (frame_no % 5 == 3);
            rx_steady = (frame_no % 5 == 3);
            if ($urandom_range(0, 9) == 0) begin
                send_cmd(hdlc_tx_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
            end else begin
                if ($urandom_range(0, 7) != 0) begin
                    send_cmd(hdlc_tx_pkg::CMD_START, 8'($urandom));
                end
                open_flag = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h7E;
                send_cmd(hdlc_tx_pkg::CMD_FLAG, open_flag);
                nbody = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(1, 8);
                for (int i = 0; i < nbody; i++) begin
                    send_cmd(hdlc_tx_pkg::CMD_BODY, pick_body_byte());
                end
                if ($urandom_range(0, 9) != 0) send_cmd(hdlc_tx_pkg::CMD_CRC, 8'($urandom));
                send_cmd(hdlc_tx_pkg::CMD_FLAG, 8'h7E);
            end
            frame_no++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain();
    endtask

    // Main sequence
    initial begin
        fcs_acc   = hdlc_tx_pkg::CRC_PRESET;
        ones_seen = '0;
        line_lvl  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random_frames();
        $display("Ran %0d commands (directed, held-off receiver, random frames)", cmds_sent);
        $display("Checked %0d line bits, %0d of them stuffed zeros", bits_seen, stuffs_seen);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("Timeout with %0d bits still owed", line_bits_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule
